FILE: src/ctba_pkg.sv
// ----------------------------------------------------------------------------
// ctba_pkg: shared definitions for the calibrated temperature averager
// Widths, register indexes, reset values and the request and response
// structs of the bit-serial divider.
// ----------------------------------------------------------------------------
package ctba_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int GRAD_W   = 13;
  localparam int CROSS_W  = 20;
  localparam int TRIM_W   = 10;
  localparam int AVG_W    = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_GRADIENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CROSSING = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TRIM     = CFG_IDX_W'(2);

  localparam logic [GRAD_W-1:0]         GRADIENT_RST = GRAD_W'(100);
  localparam logic signed [CROSS_W-1:0] CROSSING_RST = '0;
  localparam logic [TRIM_W-1:0]         TRIM_RST     = TRIM_W'(270);

  // Averaging window
  localparam int TAP_COUNT = 10;
  localparam int CNT_W     = $clog2(TAP_COUNT);
  localparam int SUM_W     = AVG_W + $clog2(TAP_COUNT);

  // Arithmetic constants
  localparam int SCALE     = 100;
  localparam int TRUNC_DIV = 10;

  // Temperature path: 10000*sample - 100*crossing always fits in 28 signed bits.
  localparam int T_W = 28;

  // Divider sizing: dividend register holds the widest operand, the window sum.
  localparam int DIV_W  = (SUM_W > T_W) ? SUM_W : T_W;
  localparam int DIVR_W = GRAD_W;
  localparam int LEN_W  = $clog2(DIV_W + 1);

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;  // top-aligned: only the upper len bits are used
    logic [DIVR_W-1:0] divisor;
    logic [LEN_W-1:0]  len;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                    en;
    logic [CNT_W-1:0]        idx;
    logic signed [AVG_W-1:0] data;
  } tap_wr_t;

endpackage

FILE: src/ctba_serdiv.sv
// ----------------------------------------------------------------------------
// ctba_serdiv: bit-serial unsigned restoring divider
// Produces one quotient bit per cycle; the dividend shifts out MSB first
// while quotient bits shift in at the bottom of the same register.
// ----------------------------------------------------------------------------
module ctba_serdiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctba_pkg::div_req_t req_i,
  output ctba_pkg::div_rsp_t rsp_o
);
  import ctba_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [DIVR_W-1:0] rem_q, rem_d;
  logic [DIVR_W-1:0] dvs_q, dvs_d;

  logic [DIVR_W:0]   shifted;
  logic [DIVR_W+1:0] diff;
  logic              ge;

  assign shifted = {rem_q, dq_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[DIVR_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.len;
      dq_d   = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      dq_d  = {dq_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
      cnt_d = cnt_q - LEN_W'(1);
      if (cnt_q == LEN_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;

endmodule

FILE: src/ctba_taps.sv
// ----------------------------------------------------------------------------
// ctba_taps: tap store of the moving-average window
// One write port and one read port; every tap clears to zero at reset.
// ----------------------------------------------------------------------------
module ctba_taps (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctba_pkg::tap_wr_t              wr_i,
  input  logic [ctba_pkg::CNT_W-1:0]     rd_idx_i,
  output logic signed [ctba_pkg::AVG_W-1:0] rd_data_o
);
  import ctba_pkg::*;

  logic signed [AVG_W-1:0] tap_q [TAP_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        tap_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      tap_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data_o = tap_q[rd_idx_i];

endmodule

FILE: src/calibrated_temperature_block_average_core.sv
// ----------------------------------------------------------------------------
// calibrated_temperature_block_average_core: calibrated sensor averager
// Converts each ADC sample to hundredths of a degree and stores it in a
// ten-tap window; every tenth sample emits the window mean first.
//
//   Channel  Handshake                 Payload
//   in       in_valid_i / in_ready_o   sample_i
//   out      out_valid_o / out_ready_i average_temp_x100_o
//   cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample takes two passes through the bit-serial divider
// (calibration divide, then truncation to tens).
// A sample that closes the window first sums all TAP_COUNT taps and
// runs a SUM_W-bit divide of the sum by TAP_COUNT for the mean.
// Reset clears the counter and all taps at once; no clearing pass.
// A stalled output beat holds the block only when the next mean is ready.
// ----------------------------------------------------------------------------
module calibrated_temperature_block_average_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ctba_pkg::SAMPLE_W-1:0]        sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ctba_pkg::AVG_W-1:0]    average_temp_x100_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ctba_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ctba_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ctba_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUM      = 4'd1;
  localparam logic [3:0] S_AVG_GO   = 4'd2;
  localparam logic [3:0] S_AVG_WAIT = 4'd3;
  localparam logic [3:0] S_EMIT     = 4'd4;
  localparam logic [3:0] S_T1_GO    = 4'd5;
  localparam logic [3:0] S_T1_WAIT  = 4'd6;
  localparam logic [3:0] S_T2_GO    = 4'd7;
  localparam logic [3:0] S_T2_WAIT  = 4'd8;

  localparam logic signed [T_W-1:0] K_SAMPLE = T_W'(SCALE * SCALE);
  localparam logic signed [T_W-1:0] K_CROSS  = T_W'(SCALE);
  localparam logic signed [T_W-1:0] K_TRUNC  = T_W'(TRUNC_DIV);

  // Configuration registers
  logic [GRAD_W-1:0]         gradient_q;
  logic signed [CROSS_W-1:0] crossing_q;
  logic [TRIM_W-1:0]         trim_q;

  // Control
  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  sum_idx_q, sum_idx_d;
  logic              out_valid_q, out_valid_d;

  // Payload
  logic signed [T_W-1:0]   t2_q, t2_d;
  logic signed [T_W-1:0]   t3_q, t3_d;
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic signed [AVG_W-1:0] out_data_q, out_data_d;

  logic                    in_acc;
  logic [CNT_W-1:0]        cnt_next;
  logic signed [T_W-1:0]   sample_ext, crossing_ext, trim_ext;
  logic [GRAD_W-1:0]       grad_eff;
  logic [T_W-1:0]          t2_mag, t3_mag;
  logic signed [T_W-1:0]   q_t, q_signed, q_tens;
  logic [SUM_W-1:0]        acc_mag;
  logic [AVG_W-1:0]        mean_mag;

  div_req_t                div_req;
  div_rsp_t                div_rsp;
  tap_wr_t                 tap_wr;
  logic signed [AVG_W-1:0] tap_rd;

  ctba_serdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ctba_taps u_taps (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tap_wr),
    .rd_idx_i  (sum_idx_q),
    .rd_data_o (tap_rd)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign cnt_next = (cnt_q == CNT_W'(TAP_COUNT - 1)) ? '0 : cnt_q + CNT_W'(1);

  assign sample_ext   = signed'({{(T_W - SAMPLE_W){1'b0}}, sample_i});
  assign crossing_ext = T_W'(crossing_q);
  assign trim_ext     = signed'({{(T_W - TRIM_W){1'b0}}, trim_q});
  assign grad_eff     = (gradient_q == '0) ? GRAD_W'(1) : gradient_q;

  assign t2_mag   = t2_q[T_W-1] ? T_W'(-t2_q) : T_W'(t2_q);
  assign t3_mag   = t3_q[T_W-1] ? T_W'(-t3_q) : T_W'(t3_q);
  assign acc_mag  = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
  assign q_t      = signed'(div_rsp.quot[T_W-1:0]);
  assign q_signed = t2_q[T_W-1] ? -q_t : q_t;
  assign q_tens   = q_t * K_TRUNC;
  assign mean_mag = div_rsp.quot[AVG_W-1:0];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    sum_idx_d    = sum_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    t2_d         = t2_q;
    t3_d         = t3_q;
    acc_d        = acc_q;
    out_data_d   = out_data_q;
    div_req      = '0;
    tap_wr       = '0;
    tap_wr.idx   = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d     = cnt_next;
          t2_d      = sample_ext * K_SAMPLE - crossing_ext * K_CROSS;
          acc_d     = '0;
          sum_idx_d = '0;
          state_d   = (cnt_next == '0) ? S_SUM : S_T1_GO;
        end
      end
      S_SUM: begin
        acc_d     = acc_q + SUM_W'(tap_rd);
        sum_idx_d = sum_idx_q + CNT_W'(1);
        if (sum_idx_q == CNT_W'(TAP_COUNT - 1)) begin
          state_d = S_AVG_GO;
        end
      end
      S_AVG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(acc_mag) << (DIV_W - SUM_W);
        div_req.divisor  = DIVR_W'(TAP_COUNT);
        div_req.len      = LEN_W'(SUM_W);
        state_d          = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // Wait for the previous mean to leave the output register.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q[SUM_W-1] ? signed'(-mean_mag) : signed'(mean_mag);
          state_d     = S_T1_GO;
        end
      end
      S_T1_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(t2_mag) << (DIV_W - T_W);
        div_req.divisor  = grad_eff;
        div_req.len      = LEN_W'(T_W);
        state_d          = S_T1_WAIT;
      end
      S_T1_WAIT: begin
        if (div_rsp.done) begin
          t3_d    = q_signed - trim_ext;
          state_d = S_T2_GO;
        end
      end
      S_T2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(t3_mag) << (DIV_W - T_W);
        div_req.divisor  = DIVR_W'(TRUNC_DIV);
        div_req.len      = LEN_W'(T_W);
        state_d          = S_T2_WAIT;
      end
      S_T2_WAIT: begin
        if (div_rsp.done) begin
          // Truncation toward zero: divide the magnitude, then restore the sign.
          tap_wr.en   = 1'b1;
          tap_wr.data = AVG_W'(t3_q[T_W-1] ? -q_tens : q_tens);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sum_idx_q   <= '0;
      out_valid_q <= 1'b0;
      gradient_q  <= GRADIENT_RST;
      crossing_q  <= CROSSING_RST;
      trim_q      <= TRIM_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_idx_q   <= sum_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_GRADIENT: gradient_q <= cfg_data_i[GRAD_W-1:0];
          REG_CROSSING: crossing_q <= signed'(cfg_data_i[CROSS_W-1:0]);
          REG_TRIM:     trim_q     <= cfg_data_i[TRIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t2_q       <= t2_d;
    t3_q       <= t3_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o         = out_valid_q;
  assign average_temp_x100_o = out_data_q;

endmodule

FILE: src/ctba_checker.sv
// ----------------------------------------------------------------------------
// ctba_checker: port-level checks for the calibrated temperature averager
// Watches the handshakes of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module ctba_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [ctba_pkg::AVG_W-1:0] average_temp_x100_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o
);

  // A stalled result beat must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled result beat must keep its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(average_temp_x100_o))
    else $error("output payload changed while stalled");

  // The block works on one sample at a time and drops its ready after taking one.
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too soon after a beat");

  // A new mean needs at least one full sample to be processed first.
  a_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while the block was idle");

  // Configuration writes are always taken.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind calibrated_temperature_block_average_core ctba_checker u_ctba_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for calibrated_temperature_block_average_core
// Drives ADC samples through the valid/ready input channel under several
// calibration settings, predicts every ten-sample window mean in the bench,
// and compares each output beat against the oldest predicted mean.
// ----------------------------------------------------------------------------
module tb;
  import ctba_pkg::*;

  localparam int     CLK_PERIOD    = 20;
  localparam int     RESET_CYCLES  = 7;
  localparam int     PHASES        = 11;
  localparam int     PHASE_ITEMS   = 100;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam int     CYCLE_LIMIT   = 1000000;
  localparam longint AVG_MAX       = 64'sd2147483647;
  localparam longint AVG_MIN       = -64'sd2147483648;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(3);

  localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [20] = '{
    12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2048, 12'd2047, 12'hAAA, 12'h555,
    12'd27, 12'd100, 12'd4095, 12'd0, 12'h800, 12'h7FF, 12'd3, 12'd999,
    12'hF0F, 12'h0F0, 12'd270, 12'd4095
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid  = 1'b0;
  logic                    in_ready_o;
  logic [SAMPLE_W-1:0]     in_sample = '0;
  logic                    out_valid_o;
  logic                    out_ready = 1'b0;
  logic signed [AVG_W-1:0] average_temp_x100_o;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  // Bench copy of the calibration registers and the averaging window.
  logic [GRAD_W-1:0]         grad_reg  = GRADIENT_RST;
  logic signed [CROSS_W-1:0] cross_reg = CROSSING_RST;
  logic [TRIM_W-1:0]         trim_reg  = TRIM_RST;
  logic signed [AVG_W-1:0]   window_taps [TAP_COUNT] = '{default: '0};
  int unsigned               slot = 0;

  logic [SAMPLE_W-1:0]     sample_q [$];
  logic signed [AVG_W-1:0] mean_q [$];

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int in_gap       = 0;
  int out_gap      = 0;
  int errors       = 0;
  int samples_sent = 0;
  int means_seen   = 0;
  int cycle_count  = 0;

  calibrated_temperature_block_average_core dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .sample_i            (in_sample),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .average_temp_x100_o (average_temp_x100_o),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(string what);
    $display("ERROR at %0t ns: %s", $time, what);
    errors++;
  endtask

  function automatic logic signed [AVG_W-1:0] clamp32(longint v);
    if (v > AVG_MAX) v = AVG_MAX;
    if (v < AVG_MIN) v = AVG_MIN;
    return v[AVG_W-1:0];
  endfunction

  // Two-point calibration, then trim and truncation toward zero to tens.
  function automatic logic signed [AVG_W-1:0] calibrate(logic [SAMPLE_W-1:0] s);
    longint g;
    longint t;
    g = (grad_reg == '0) ? 1 : longint'(grad_reg);
    t = SCALE * longint'(s) - longint'(cross_reg);
    t = (SCALE * t) / g;
    t = t - longint'(trim_reg);
    t = (t / TRUNC_DIV) * TRUNC_DIV;
    return clamp32(t);
  endfunction

  // The mean covers the window as it stood before this sample is written.
  function automatic void predict_sample(logic [SAMPLE_W-1:0] s);
    logic signed [AVG_W-1:0] temp;
    longint acc;
    temp = calibrate(s);
    slot = (slot + 1) % TAP_COUNT;
    if (slot == 0) begin
      acc = 0;
      foreach (window_taps[i]) acc += window_taps[i];
      mean_q.push_back(clamp32(acc / TAP_COUNT));
    end
    window_taps[slot] = temp;
  endfunction

  always @(posedge clk) begin : sample_driver
    bit fire;
    fire = in_valid && in_ready_o;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        predict_sample(in_sample);
        samples_sent++;
      end
      if (!in_valid || fire) begin
        if (sample_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid  <= 1'b1;
          in_sample <= sample_q.pop_front();
        end
      end
    end
  end

  always @(posedge clk) begin : mean_monitor
    logic signed [AVG_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (mean_q.size() == 0) begin
          report_mismatch($sformatf("mean beat %0d with none expected",
                                    average_temp_x100_o));
        end else begin
          want = mean_q.pop_front();
          means_seen++;
          if (average_temp_x100_o !== want)
            report_mismatch($sformatf("average_temp_x100 got %0d, expected %0d",
                                      average_temp_x100_o, want));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d means still pending.",
               cycle_count, mean_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      REG_GRADIENT: grad_reg = data[GRAD_W-1:0];
      REG_CROSSING: cross_reg = data[CROSS_W-1:0];
      REG_TRIM:     trim_reg = data[TRIM_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Bits above the gradient and trim fields carry random junk, which the block must drop.
  task automatic apply_config(logic [GRAD_W-1:0] g, logic signed [CROSS_W-1:0] c,
                              logic [TRIM_W-1:0] tr, bit stray);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[GRAD_W-1:0] = g;
    write_reg(REG_GRADIENT, word);
    write_reg(REG_CROSSING, c);
    word = CFG_DATA_W'($urandom);
    word[TRIM_W-1:0] = tr;
    write_reg(REG_TRIM, word);
    if (stray) write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
  endtask

  // All samples in, all means out, then enough slack for a sample that
  // produces no mean to finish before the next register write.
  task automatic wait_idle();
    int guard;
    guard = 0;
    while (sample_q.size() > 0 || in_valid) @(posedge clk);
    while (mean_q.size() > 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mean_q.size() > 0) begin
      report_mismatch($sformatf("%0d expected means never arrived", mean_q.size()));
      mean_q.delete();
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [GRAD_W-1:0]         g;
    logic signed [CROSS_W-1:0] c;
    logic [TRIM_W-1:0]         tr;
    bit                        stray;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration; the first mean still includes a cleared tap.
    foreach (EDGE_SAMPLES[i]) sample_q.push_back(EDGE_SAMPLES[i]);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      stray = ($urandom_range(0, 1) == 1);
      case (p)
        0: begin g = 1;    c = -262144; tr = 0;    end
        1: begin g = 8191; c = 524287;  tr = 1023; end
        2: begin g = 0;    c = 0;       tr = 1023; stray = 1'b1; end
        3: begin g = 1;    c = 524287;  tr = 1023; end
        4: begin g = 8191; c = -524288; tr = 0;    end
        default: begin
          if ($urandom_range(0, 9) == 0) g = '0;
          else if ($urandom_range(0, 1) == 1) g = GRAD_W'($urandom_range(50, 500));
          else g = GRAD_W'($urandom_range(1, 8191));
          c  = CROSS_W'($urandom);
          tr = TRIM_W'($urandom);
        end
      endcase
      apply_config(g, c, tr, stray);
      if (p == PHASES - 1) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 90);
        out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
      end
      repeat (PHASE_ITEMS) sample_q.push_back(pick_sample());
      wait_idle();
    end

    $display("Ran %0d samples under %0d calibration settings with random stalls.",
             samples_sent, PHASES + 1);
    $display("Checked %0d window means; %0d mismatches.", means_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
